// ----- hw/rtl/lsf_pkg.sv -----
// lsf_pkg: widths, types, state and status codes for the line fit block
package lsf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int W_X         = 16;
    localparam int W_L         = $clog2(MAX_SAMPLES);
    localparam int W_CNT       = $clog2(MAX_SAMPLES + 1);
    localparam int W_SX        = W_X + W_L;
    localparam int W_SXY       = 2 * W_X + W_L;
    localparam int W_SXX       = 2 * W_X + W_L - 1;
    localparam int W_B         = W_SX;
    localparam int W_ACC_A     = 2 * W_X + 2 * W_L + 2;
    localparam int W_ACC_B     = W_X + W_L + 34;
    localparam int W_ACC       = (W_ACC_A > W_ACC_B) ? W_ACC_A : W_ACC_B;
    localparam int W_U         = W_ACC + 1;
    localparam int W_FRAC      = 16;
    localparam int W_DVD       = W_ACC + W_FRAC;
    localparam int W_STEP      = $clog2(W_DVD);
    localparam int W_Q         = 33;
    localparam int W_RES       = 32;
    localparam int ICPT_SHIFT  = 8;

    typedef logic signed [W_SX-1:0]  t_sx;
    typedef logic        [W_B-1:0]   t_b;
    typedef logic signed [W_ACC-1:0] t_acc;
    typedef logic signed [W_U-1:0]   t_u;
    typedef logic signed [W_RES-1:0] t_res;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZVAR = 2'd1,
        ST_CAP  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MXY,
        S_MXX,
        S_NUM1,
        S_NUM2,
        S_DEN1,
        S_DEN2,
        S_NEG,
        S_DIV,
        S_FIN,
        S_ICP,
        S_OUT
    } t_state;

    function automatic t_b mag_b(input t_sx v);
        t_sx neg_v;
        neg_v = -v;
        return v[W_SX-1] ? t_b'(neg_v) : t_b'(v);
    endfunction

endpackage

// ----- hw/rtl/lsf_alu.sv -----
// lsf_alu: shared add/subtract unit for multiply, negate and divide steps
module lsf_alu (
    input  lsf_pkg::t_u i_a,
    input  lsf_pkg::t_u i_b,
    input  logic        i_sub,
    output lsf_pkg::t_u o_sum
);

    lsf_pkg::t_u b_inv;

    assign b_inv = i_b ^ {lsf_pkg::W_U{i_sub}};
    assign o_sum = i_a + b_inv + lsf_pkg::t_u'(i_sub);

endmodule

// ----- hw/rtl/least_squares_line_fit.sv -----
// least_squares_line_fit: streaming least-squares line fit over q8.8 sample pairs
//
//  channel   | dir | tdata (low bit up)                | tuser         | tlast
//  ----------+-----+-----------------------------------+---------------+------------
//  s_axis    | in  | x_sample[15:0], y_sample[31:16]   | -             | last_sample
//  m_axis    | out | slope[31:0], intercept[63:32]     | fit_status    | -
//
//  a kept pair runs two shift-add multiplies on one shared adder,
//  each ending when the remaining multiplier bits are zero
//  a pair marked last then runs the four cross products, the slope divide, the
//  intercept product and the intercept divide
//  o_s_axis_tready is high only in the idle state; reset clears the sums, count and output valid
//  a result waits in the output register while the next pairs are accumulated
module least_squares_line_fit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // x_sample, y_sample
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // slope, intercept
    output logic [1:0]  o_m_axis_tuser    // fit_status
);

    lsf_pkg::t_state r_state, n_state;
    lsf_pkg::t_sx    r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic signed [lsf_pkg::W_SXY-1:0] r_sum_xy, n_sum_xy;
    logic [lsf_pkg::W_SXX-1:0]        r_sum_xx, n_sum_xx;
    logic [lsf_pkg::W_CNT-1:0]        r_count, n_count;
    logic                             r_ovf, n_ovf;
    logic signed [lsf_pkg::W_X-1:0]   r_x, n_x;
    logic                             r_last, n_last;
    lsf_pkg::t_acc                    r_acc, n_acc, r_a, n_a, r_num, n_num, r_den, n_den;
    lsf_pkg::t_b                      r_b, n_b;
    logic                             r_neg, n_neg;
    logic                             r_phase, n_phase;
    logic [lsf_pkg::W_DVD-1:0]        r_dvd, n_dvd;
    logic [lsf_pkg::W_ACC-1:0]        r_rem, n_rem;
    logic [lsf_pkg::W_Q-1:0]          r_q, n_q;
    logic                             r_big, n_big, r_qneg, n_qneg;
    logic [lsf_pkg::W_STEP-1:0]       r_step, n_step;
    lsf_pkg::t_res                    r_slope, n_slope, r_icpt, n_icpt;
    logic                             r_zvar, n_zvar;
    logic                             r_out_valid, n_out_valid;
    lsf_pkg::t_res                    r_out_slope, n_out_slope, r_out_icpt, n_out_icpt;
    lsf_pkg::t_status                 r_out_status, n_out_status;

    logic signed [lsf_pkg::W_X-1:0] in_x, in_y;
    logic                           accept;
    logic                           mac_st, mac_done;
    lsf_pkg::t_u                    alu_a, alu_b, alu_sum;
    logic                           alu_sub;
    logic [lsf_pkg::W_ACC-1:0]      rem_sh, mag;
    logic                           fits;
    logic                           q_hi;
    lsf_pkg::t_res                  q_neg, sat;

    assign in_x            = i_s_axis_tdata[15:0];
    assign in_y            = i_s_axis_tdata[31:16];
    assign o_s_axis_tready = (r_state == lsf_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    assign mac_st   = r_state inside {lsf_pkg::S_MXY, lsf_pkg::S_MXX, lsf_pkg::S_NUM1,
                                      lsf_pkg::S_NUM2, lsf_pkg::S_DEN1, lsf_pkg::S_DEN2,
                                      lsf_pkg::S_ICP};
    assign mac_done = (r_b == '0);
    assign rem_sh   = {r_rem[lsf_pkg::W_ACC-2:0], r_dvd[lsf_pkg::W_DVD-1]};
    assign fits     = ~alu_sum[lsf_pkg::W_U-1];
    assign mag      = r_acc[lsf_pkg::W_ACC-1] ? alu_sum[lsf_pkg::W_ACC-1:0] : r_acc;

    // shared adder operand select
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        if (mac_st) begin
            alu_a   = lsf_pkg::t_u'(r_acc);
            alu_b   = lsf_pkg::t_u'(r_a);
            alu_sub = r_neg;
        end else if (r_state == lsf_pkg::S_NEG) begin
            alu_b   = lsf_pkg::t_u'(r_acc);
            alu_sub = 1'b1;
        end else if (r_state == lsf_pkg::S_DIV) begin
            alu_a   = lsf_pkg::t_u'(rem_sh);
            alu_b   = lsf_pkg::t_u'(r_den);
            alu_sub = 1'b1;
        end
    end

    lsf_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    // truncated quotient magnitude to saturated q16.16
    always_comb begin
        q_hi  = r_big | r_q[lsf_pkg::W_Q-1];
        q_neg = -lsf_pkg::t_res'(r_q[lsf_pkg::W_RES-1:0]);
        if (!r_qneg) begin
            sat = (q_hi | r_q[lsf_pkg::W_RES-1])
                ? lsf_pkg::t_res'({1'b0, {(lsf_pkg::W_RES-1){1'b1}}})
                : lsf_pkg::t_res'(r_q[lsf_pkg::W_RES-1:0]);
        end else begin
            sat = (q_hi | (r_q[lsf_pkg::W_RES-1] & (|r_q[lsf_pkg::W_RES-2:0])))
                ? lsf_pkg::t_res'({1'b1, {(lsf_pkg::W_RES-1){1'b0}}})
                : q_neg;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sum_x      = r_sum_x;
        n_sum_y      = r_sum_y;
        n_sum_xy     = r_sum_xy;
        n_sum_xx     = r_sum_xx;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_x          = r_x;
        n_last       = r_last;
        n_acc        = r_acc;
        n_a          = r_a;
        n_b          = r_b;
        n_neg        = r_neg;
        n_num        = r_num;
        n_den        = r_den;
        n_phase      = r_phase;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_q          = r_q;
        n_big        = r_big;
        n_qneg       = r_qneg;
        n_step       = r_step;
        n_slope      = r_slope;
        n_icpt       = r_icpt;
        n_zvar       = r_zvar;
        n_out_valid  = r_out_valid & ~i_m_axis_tready;
        n_out_slope  = r_out_slope;
        n_out_icpt   = r_out_icpt;
        n_out_status = r_out_status;

        // shift-add step of the running multiply
        if (mac_st && !mac_done) begin
            if (r_b[0]) begin
                n_acc = alu_sum[lsf_pkg::W_ACC-1:0];
            end
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
        end

        case (r_state)
            lsf_pkg::S_IDLE: begin
                if (accept) begin
                    n_last = i_s_axis_tlast;
                    if (r_count < lsf_pkg::W_CNT'(lsf_pkg::MAX_SAMPLES)) begin
                        n_sum_x = r_sum_x + lsf_pkg::t_sx'(in_x);
                        n_sum_y = r_sum_y + lsf_pkg::t_sx'(in_y);
                        n_count = r_count + 1'b1;
                        n_x     = in_x;
                        n_acc   = lsf_pkg::t_acc'(r_sum_xy);
                        n_a     = lsf_pkg::t_acc'(in_x);
                        n_b     = lsf_pkg::mag_b(lsf_pkg::t_sx'(in_y));
                        n_neg   = in_y[lsf_pkg::W_X-1];
                        n_state = lsf_pkg::S_MXY;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_s_axis_tlast) begin
                            n_acc   = '0;
                            n_a     = lsf_pkg::t_acc'(r_sum_xy);
                            n_b     = lsf_pkg::t_b'(r_count);
                            n_neg   = 1'b0;
                            n_state = lsf_pkg::S_NUM1;
                        end
                    end
                end
            end
            lsf_pkg::S_MXY: begin
                if (mac_done) begin
                    n_sum_xy = r_acc[lsf_pkg::W_SXY-1:0];
                    n_acc    = lsf_pkg::t_acc'(r_sum_xx);
                    n_a      = lsf_pkg::t_acc'(r_x);
                    n_b      = lsf_pkg::mag_b(lsf_pkg::t_sx'(r_x));
                    n_neg    = r_x[lsf_pkg::W_X-1];
                    n_state  = lsf_pkg::S_MXX;
                end
            end
            lsf_pkg::S_MXX: begin
                if (mac_done) begin
                    n_sum_xx = r_acc[lsf_pkg::W_SXX-1:0];
                    if (r_last) begin
                        n_acc   = '0;
                        n_a     = lsf_pkg::t_acc'(r_sum_xy);
                        n_b     = lsf_pkg::t_b'(r_count);
                        n_neg   = 1'b0;
                        n_state = lsf_pkg::S_NUM1;
                    end else begin
                        n_state = lsf_pkg::S_IDLE;
                    end
                end
            end
            lsf_pkg::S_NUM1: begin
                if (mac_done) begin
                    n_a     = lsf_pkg::t_acc'(r_sum_x);
                    n_b     = lsf_pkg::mag_b(r_sum_y);
                    n_neg   = ~r_sum_y[lsf_pkg::W_SX-1];
                    n_state = lsf_pkg::S_NUM2;
                end
            end
            lsf_pkg::S_NUM2: begin
                if (mac_done) begin
                    n_num   = r_acc;
                    n_acc   = '0;
                    n_a     = lsf_pkg::t_acc'(r_sum_xx);
                    n_b     = lsf_pkg::t_b'(r_count);
                    n_neg   = 1'b0;
                    n_state = lsf_pkg::S_DEN1;
                end
            end
            lsf_pkg::S_DEN1: begin
                if (mac_done) begin
                    n_a     = lsf_pkg::t_acc'(r_sum_x);
                    n_b     = lsf_pkg::mag_b(r_sum_x);
                    n_neg   = ~r_sum_x[lsf_pkg::W_SX-1];
                    n_state = lsf_pkg::S_DEN2;
                end
            end
            lsf_pkg::S_DEN2: begin
                if (mac_done) begin
                    if (r_acc[lsf_pkg::W_ACC-1] || (r_acc == '0)) begin
                        n_slope = '0;
                        n_icpt  = '0;
                        n_zvar  = 1'b1;
                        n_state = lsf_pkg::S_OUT;
                    end else begin
                        n_zvar  = 1'b0;
                        n_den   = r_acc;
                        n_acc   = r_num;
                        n_phase = 1'b0;
                        n_state = lsf_pkg::S_NEG;
                    end
                end
            end
            lsf_pkg::S_NEG: begin
                n_dvd   = r_phase ? {{lsf_pkg::W_FRAC{1'b0}}, mag} : {mag, {lsf_pkg::W_FRAC{1'b0}}};
                n_qneg  = r_acc[lsf_pkg::W_ACC-1];
                n_rem   = '0;
                n_q     = '0;
                n_big   = 1'b0;
                n_step  = '0;
                n_state = lsf_pkg::S_DIV;
            end
            lsf_pkg::S_DIV: begin
                n_rem  = fits ? alu_sum[lsf_pkg::W_ACC-1:0] : rem_sh;
                n_dvd  = r_dvd << 1;
                n_big  = r_big | r_q[lsf_pkg::W_Q-1];
                n_q    = {r_q[lsf_pkg::W_Q-2:0], fits};
                n_step = r_step + 1'b1;
                if (r_step == lsf_pkg::W_STEP'(lsf_pkg::W_DVD - 1)) begin
                    n_state = lsf_pkg::S_FIN;
                end
            end
            lsf_pkg::S_FIN: begin
                if (!r_phase) begin
                    n_slope = sat;
                    n_acc   = lsf_pkg::t_acc'(r_sum_y) <<< lsf_pkg::W_FRAC;
                    n_a     = lsf_pkg::t_acc'(sat);
                    n_b     = lsf_pkg::mag_b(r_sum_x);
                    n_neg   = ~r_sum_x[lsf_pkg::W_SX-1];
                    n_den   = lsf_pkg::t_acc'({r_count, {lsf_pkg::ICPT_SHIFT{1'b0}}});
                    n_phase = 1'b1;
                    n_state = lsf_pkg::S_ICP;
                end else begin
                    n_icpt  = sat;
                    n_state = lsf_pkg::S_OUT;
                end
            end
            lsf_pkg::S_ICP: begin
                if (mac_done) begin
                    n_state = lsf_pkg::S_NEG;
                end
            end
            lsf_pkg::S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_slope  = r_slope;
                    n_out_icpt   = r_icpt;
                    n_out_status = r_zvar ? lsf_pkg::ST_ZVAR
                                          : (r_ovf ? lsf_pkg::ST_CAP : lsf_pkg::ST_OK);
                    n_sum_x      = '0;
                    n_sum_y      = '0;
                    n_sum_xy     = '0;
                    n_sum_xx     = '0;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_state      = lsf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsf_pkg::S_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xy    <= '0;
            r_sum_xx    <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_xy    <= n_sum_xy;
            r_sum_xx    <= n_sum_xx;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_last       <= n_last;
        r_acc        <= n_acc;
        r_a          <= n_a;
        r_b          <= n_b;
        r_neg        <= n_neg;
        r_num        <= n_num;
        r_den        <= n_den;
        r_phase      <= n_phase;
        r_dvd        <= n_dvd;
        r_rem        <= n_rem;
        r_q          <= n_q;
        r_big        <= n_big;
        r_qneg       <= n_qneg;
        r_step       <= n_step;
        r_slope      <= n_slope;
        r_icpt       <= n_icpt;
        r_zvar       <= n_zvar;
        r_out_slope  <= n_out_slope;
        r_out_icpt   <= n_out_icpt;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_icpt, r_out_slope};
    assign o_m_axis_tuser  = r_out_status;

endmodule
